### design/h2r_pkg.sv
// shared types, constants and helper functions for the hsv to rgb converter
package h2r_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

  // one input transaction
  typedef struct packed {
    logic signed [15:0] hue;
    logic [7:0]         saturation;
    logic [7:0]         brightness;
  } h2r_in_t;

  // one result transaction
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } h2r_out_t;

  // colour wheel sextants
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } h2r_sextant_t;

  // after hue reduction
  typedef struct packed {
    h2r_sextant_t       sextant;
    logic [LEVEL_W-1:0] ramp;
    logic [7:0]         saturation;
    logic [7:0]         brightness;
  } h2r_hue_t;

  // after desaturation
  typedef struct packed {
    logic [LEVEL_W-1:0] lvl_red;
    logic [LEVEL_W-1:0] lvl_green;
    logic [LEVEL_W-1:0] lvl_blue;
    logic [7:0]         brightness;
  } h2r_lvl_t;

  // floor(hue / 512) mod 3, from the top seven hue bits
  // offset by 66 (64 to make it unsigned, plus 2 to keep a multiple of 3), then reciprocal multiply by 171/512
  function automatic logic [1:0] hue_block_mod3(input logic [6:0] top_bits);
    logic [7:0]  t;
    logic [14:0] prod;
    logic [7:0]  q;
    logic [7:0]  rem;
    begin
      t    = {1'b0, ~top_bits[6], top_bits[5:0]} + 8'd2;
      prod = 15'(t) * 15'd171;
      q    = {2'b00, prod[14:9]};
      rem  = t - 8'(q * 8'd3);
      if (rem >= 8'd3) begin
        rem = rem - 8'd3;
      end
      hue_block_mod3 = rem[1:0];
    end
  endfunction

  // 255 - (((255 - level) * (sat + 1)) >> 8)
  function automatic logic [LEVEL_W-1:0] desaturate(input logic [LEVEL_W-1:0] level,
                                                     input logic [8:0] sat1);
    logic [16:0] prod;
    begin
      prod       = 17'(FULL_LEVEL - level) * 17'(sat1);
      desaturate = FULL_LEVEL - prod[15:8];
    end
  endfunction

endpackage

### design/h2r_hue_stage.sv
// stage one: hue reduction modulo 1536 into sextant and ramp
module h2r_hue_stage import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_in,
  input  h2r_in_t  data_in,
  input  logic     ready_dn,
  output logic     ready_up,
  output logic     valid_r,
  output h2r_hue_t data_r
);

  logic     valid_nxt;
  h2r_hue_t data_nxt;
  logic [1:0] blk;

  assign ready_up = !valid_r || ready_dn;

  always_comb begin
    blk                 = hue_block_mod3(data_in.hue[15:9]);
    data_nxt.sextant    = h2r_sextant_t'({blk, data_in.hue[8]});
    data_nxt.ramp       = data_in.hue[7:0];
    data_nxt.saturation = data_in.saturation;
    data_nxt.brightness = data_in.brightness;
    valid_nxt           = ready_up ? valid_in : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

### design/h2r_sat_stage.sv
// stage two: sextant to channel levels, then desaturation
module h2r_sat_stage import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_in,
  input  h2r_hue_t data_in,
  input  logic     ready_dn,
  output logic     ready_up,
  output logic     valid_r,
  output h2r_lvl_t data_r
);

  logic     valid_nxt;
  h2r_lvl_t data_nxt;
  logic [LEVEL_W-1:0] r_lvl;
  logic [LEVEL_W-1:0] g_lvl;
  logic [LEVEL_W-1:0] b_lvl;
  logic [LEVEL_W-1:0] fall;
  logic [8:0]         sat1;

  assign ready_up = !valid_r || ready_dn;

  always_comb begin
    fall = FULL_LEVEL - data_in.ramp;
    case (data_in.sextant)
      SEXT_RED_YEL: begin
        r_lvl = FULL_LEVEL;   g_lvl = data_in.ramp; b_lvl = '0;
      end
      SEXT_YEL_GRN: begin
        r_lvl = fall;         g_lvl = FULL_LEVEL;   b_lvl = '0;
      end
      SEXT_GRN_CYN: begin
        r_lvl = '0;           g_lvl = FULL_LEVEL;   b_lvl = data_in.ramp;
      end
      SEXT_CYN_BLU: begin
        r_lvl = '0;           g_lvl = fall;         b_lvl = FULL_LEVEL;
      end
      SEXT_BLU_MAG: begin
        r_lvl = data_in.ramp; g_lvl = '0;           b_lvl = FULL_LEVEL;
      end
      default: begin
        r_lvl = FULL_LEVEL;   g_lvl = '0;           b_lvl = fall;
      end
    endcase
    sat1                = {1'b0, data_in.saturation} + 9'd1;
    data_nxt.lvl_red    = desaturate(r_lvl, sat1);
    data_nxt.lvl_green  = desaturate(g_lvl, sat1);
    data_nxt.lvl_blue   = desaturate(b_lvl, sat1);
    data_nxt.brightness = data_in.brightness;
    valid_nxt           = ready_up ? valid_in : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

### design/h2r_scale_stage.sv
// stage three: brightness scaling into the output register
module h2r_scale_stage import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_in,
  input  h2r_lvl_t data_in,
  input  logic     stall_dn,
  output logic     ready_up,
  output logic     valid_r,
  output h2r_out_t data_r
);

  logic     valid_nxt;
  h2r_out_t data_nxt;
  logic [8:0]  val1;
  logic [16:0] p_red;
  logic [16:0] p_green;
  logic [16:0] p_blue;

  assign ready_up = !valid_r || !stall_dn;

  always_comb begin
    val1           = {1'b0, data_in.brightness} + 9'd1;
    p_red          = 17'(data_in.lvl_red) * 17'(val1);
    p_green        = 17'(data_in.lvl_green) * 17'(val1);
    p_blue         = 17'(data_in.lvl_blue) * 17'(val1);
    data_nxt.red   = p_red[15:0];
    data_nxt.green = p_green[15:0];
    data_nxt.blue  = p_blue[15:0];
    valid_nxt      = ready_up ? valid_in : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

### design/hsv_to_rgb_converter_top.sv
// top level of the hsv to rgb converter: three-stage pipeline
// Converts one HSV colour per transaction into 16-bit red, green and blue. The
// signed hue wraps every 1536 units (six sextants of 256, negative hues wrap up),
// saturation 0..255 pulls each channel toward full scale and brightness + 1
// scales the result, so outputs run 0..65280. The pipeline takes one transaction
// every clock unless stalled, and a result passes through three register stages
// on its way to the outputs (the accepting edge loads the first):
// stage one reduces the hue, stage two picks the channel ramps and runs the
// three saturation multipliers, stage three runs the three brightness
// multipliers into the output register. Each stage has its own valid bit and
// accepts new data when it is empty or its successor takes its contents, so
// bubbles are squeezed out and in_stall only rises when all three stages are
// full and out_stall is high. Reset clears the valid bits; the data registers
// are not reset and there is nothing to configure.
module hsv_to_rgb_converter_top import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  // input channel
  input  logic     in_valid,
  output logic     in_stall,
  input  h2r_in_t  in_data,
  // result channel
  output logic     out_valid,
  input  logic     out_stall,
  output h2r_out_t out_data
);

  // stage one to stage two
  logic     hue_valid;
  h2r_hue_t hue_data;
  logic     hue_ready;

  // stage two to stage three
  logic     lvl_valid;
  h2r_lvl_t lvl_data;

  logic     sat_ready;
  logic     scl_ready;

  // hue modulo 1536, sextant and ramp
  h2r_hue_stage u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (in_valid),
    .data_in  (in_data),
    .ready_dn (sat_ready),
    .ready_up (hue_ready),
    .valid_r  (hue_valid),
    .data_r   (hue_data)
  );

  // channel levels and desaturation
  h2r_sat_stage u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (hue_valid),
    .data_in  (hue_data),
    .ready_dn (scl_ready),
    .ready_up (sat_ready),
    .valid_r  (lvl_valid),
    .data_r   (lvl_data)
  );

  // brightness scaling, doubles as the output register
  h2r_scale_stage u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (lvl_valid),
    .data_in  (lvl_data),
    .stall_dn (out_stall),
    .ready_up (scl_ready),
    .valid_r  (out_valid),
    .data_r   (out_data)
  );

  // upstream sees a stall exactly when stage one is held
  assign in_stall  = !hue_ready;

endmodule

### design/h2r_checker.sv
// port-level assertions for the hsv to rgb converter and their bind
module h2r_checker import h2r_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input h2r_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input h2r_out_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // full throughput when downstream takes everything
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with no output back-pressure");

  // channels stay within 255 * 256
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red <= 16'd65280) && (out_data.green <= 16'd65280)
                  && (out_data.blue <= 16'd65280))
    else $error("channel out of range");

  // in_valid and in_data come in through the bind, but no assertion uses them
  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

endmodule

bind hsv_to_rgb_converter_top h2r_checker u_h2r_checker (.*);

### test/hsv_to_rgb_converter_checker.sv
// checker for the hsv to rgb converter: predicts each color and compares results
module hsv_to_rgb_converter_checker import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  h2r_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  h2r_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  h2r_out_t expected_colors[$];

  // one channel level pulled toward full scale, then scaled by brightness + 1
  function automatic logic [15:0] shade_level(input logic [7:0] level,
                                              input logic [7:0] sat,
                                              input logic [7:0] bright);
    int faded;
    begin
      faded = 255 - (((255 - int'(level)) * (int'(sat) + 1)) >>> 8);
      shade_level = 16'(faded * (int'(bright) + 1));
    end
  endfunction

  function automatic h2r_out_t hsv_to_rgb(input h2r_in_t c);
    int            wheel;
    logic [7:0]    ramp;
    logic [7:0]    lvl_r, lvl_g, lvl_b;
    h2r_sextant_t  sext;
    h2r_out_t      rgb;
    begin
      // remainder truncates toward zero, negative hues wrap up
      wheel = $signed(c.hue);
      wheel = wheel % 1536;
      if (wheel < 0) begin
        wheel = wheel + 1536;
      end
      ramp = wheel[7:0];
      sext = h2r_sextant_t'(wheel[10:8]);
      case (sext)
        SEXT_RED_YEL: begin
          lvl_r = 8'hFF;        lvl_g = ramp;         lvl_b = 8'h00;
        end
        SEXT_YEL_GRN: begin
          lvl_r = 8'hFF - ramp; lvl_g = 8'hFF;        lvl_b = 8'h00;
        end
        SEXT_GRN_CYN: begin
          lvl_r = 8'h00;        lvl_g = 8'hFF;        lvl_b = ramp;
        end
        SEXT_CYN_BLU: begin
          lvl_r = 8'h00;        lvl_g = 8'hFF - ramp; lvl_b = 8'hFF;
        end
        SEXT_BLU_MAG: begin
          lvl_r = ramp;         lvl_g = 8'h00;        lvl_b = 8'hFF;
        end
        default: begin
          lvl_r = 8'hFF;        lvl_g = 8'h00;        lvl_b = 8'hFF - ramp;
        end
      endcase
      rgb.red   = shade_level(lvl_r, c.saturation, c.brightness);
      rgb.green = shade_level(lvl_g, c.saturation, c.brightness);
      rgb.blue  = shade_level(lvl_b, c.saturation, c.brightness);
      hsv_to_rgb = rgb;
    end
  endfunction

  always @(posedge clk) begin
    h2r_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   out_data.red, out_data.green, out_data.blue);
          fail_count = fail_count + 1;
        end else begin
          want = expected_colors.pop_front();
          checked = checked + 1;
          if (out_data.red !== want.red) begin
            $display("%0t: red expected %0d got %0d", $time, want.red, out_data.red);
            fail_count = fail_count + 1;
          end
          if (out_data.green !== want.green) begin
            $display("%0t: green expected %0d got %0d", $time, want.green,
                     out_data.green);
            fail_count = fail_count + 1;
          end
          if (out_data.blue !== want.blue) begin
            $display("%0t: blue expected %0d got %0d", $time, want.blue, out_data.blue);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_colors.push_back(hsv_to_rgb(in_data));
      end
      pending = expected_colors.size();
    end else begin
      expected_colors.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
    end
  end

endmodule

### test/testbench.sv
// top of the hsv to rgb converter testbench: stimulus, stalls and verdict
module testbench import h2r_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  h2r_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  h2r_out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int cycle_count;
  int send_gap_pct;
  int recv_stall_pct;
  int hold_requests;

  hsv_to_rgb_converter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsv_to_rgb_converter_checker color_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending);
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off for each request so the
  // pipeline fills and pushes back on the input side
  initial begin
    int held;
    int holds_done;
    out_stall = 1'b0;
    held = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        held = held + 1;
        if (held >= HOLD_CYCLES) begin
          holds_done = holds_done + 1;
          held = 0;
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic h2r_in_t make_color(input int hue, input int sat, input int bright);
    h2r_in_t c;
    begin
      c.hue        = 16'(hue);
      c.saturation = 8'(sat);
      c.brightness = 8'(bright);
      make_color = c;
    end
  endfunction

  // mix of full-range hues, hues on the wheel and hues at sextant borders;
  // saturation and brightness lean on their extremes now and then
  function automatic h2r_in_t random_color();
    h2r_in_t c;
    int      pick;
    int      border;
    begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        c.hue = 16'($urandom);
      end else if (pick < 8) begin
        c.hue = 16'($urandom_range(1535));
      end else begin
        border = (int'($urandom_range(255)) - 128) * 256 + int'($urandom_range(2)) - 1;
        c.hue = 16'(border);
      end
      pick = $urandom_range(7);
      c.saturation = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      pick = $urandom_range(7);
      c.brightness = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      random_color = c;
    end
  endfunction

  // offer one transaction, entered and left at a falling edge; valid only
  // drops when a gap is actually taken
  task automatic send_color(input h2r_in_t c);
    bit taken;
    begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= c;
      taken = 1'b0;
      while (!taken) begin
        @(posedge clk);
        taken = !in_stall;
      end
      sent = sent + 1;
      @(negedge clk);
    end
  endtask

  // hold the sender back until every predicted color has come out
  task automatic drain_results();
    begin
      in_valid <= 1'b0;
      while (pending != 0) begin
        @(negedge clk);
      end
    end
  endtask

  task automatic send_random(input int count);
    begin
      repeat (count) begin
        send_color(random_color());
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    sent           = 0;
    hold_requests  = 0;
    send_gap_pct   = 13;
    recv_stall_pct = 86;

    // synchronous reset, held low at the start
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: both ends of every sextant at full color and brightness
    send_color(make_color(0, 255, 255));
    send_color(make_color(255, 255, 255));
    send_color(make_color(256, 255, 255));
    send_color(make_color(511, 255, 255));
    send_color(make_color(512, 255, 255));
    send_color(make_color(767, 255, 255));
    send_color(make_color(768, 255, 255));
    send_color(make_color(1023, 255, 255));
    send_color(make_color(1024, 255, 255));
    send_color(make_color(1279, 255, 255));
    send_color(make_color(1280, 255, 255));
    send_color(make_color(1535, 255, 255));
    // wrap points and negative hues, including the signed extremes
    send_color(make_color(1536, 255, 255));
    send_color(make_color(-1, 255, 255));
    send_color(make_color(-1536, 200, 128));
    send_color(make_color(-1537, 1, 254));
    send_color(make_color(-32768, 128, 200));
    send_color(make_color(32767, 77, 33));
    // white at zero saturation, black at zero brightness
    send_color(make_color(-256, 0, 255));
    send_color(make_color(700, 0, 0));
    send_color(make_color(100, 255, 0));
    send_color(make_color(16'h5555, 8'hAA, 8'h55));
    send_color(make_color(16'hAAAA, 8'h55, 8'hAA));
    drain_results();

    // phase one: sender mostly busy, receiver mostly stalled
    send_random(450);
    drain_results();

    // phase two: the other way round
    send_gap_pct   = 86;
    recv_stall_pct = 13;
    send_random(450);
    drain_results();

    // phase three: no idling, with one long receiver hold-off in the middle
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random(200);
    hold_requests = hold_requests + 1;
    send_random(100);
    drain_results();
    send_random(200);

    // let the pipeline empty, then wait on for any stray result
    drain_results();
    repeat (10) @(negedge clk);

    $display("covered %0d colors (%0d results checked): sextant borders, wrap of signed",
             sent, checked);
    $display("hues, zero and full saturation and brightness, under both stall patterns");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
